/* hw/rtl/rptm_pkg.sv */
// shared types, class colors and gamma threshold generation for the ray pixel tone mapper
package rptm_pkg;

  typedef enum logic [2:0] {
    CLS_CAPTURED    = 3'd0,
    CLS_ESCAPED     = 3'd1,
    CLS_DISK_HIT    = 3'd2,
    CLS_UNCONVERGED = 3'd3,
    CLS_CONSTRAINT  = 3'd4,
    CLS_INIT_ERROR  = 3'd5,
    CLS_TRANSFER    = 3'd6,
    CLS_UNKNOWN     = 3'd7
  } rptm_class_t;

  typedef struct packed {
    logic        valid;
    rptm_class_t ray_class;
  } rptm_tag_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rptm_rgb_t;

  localparam int          INTENSITY_W   = 32;
  localparam int          EXPOSURE_W    = 24;
  localparam int          FRAC_W        = 16;
  localparam int          DEN_W         = INTENSITY_W + 1;
  localparam logic [23:0] EXPOSURE_INIT = 24'h010000;

  function automatic rptm_rgb_t class_color(input rptm_class_t cls);
    rptm_rgb_t c;
    case (cls)
      CLS_CAPTURED:    c = '{blue: 8'd0,   green: 8'd0,   red: 8'd0};
      CLS_ESCAPED:     c = '{blue: 8'd235, green: 8'd235, red: 8'd235};
      CLS_DISK_HIT:    c = '{blue: 8'd255, green: 8'd200, red: 8'd0};
      CLS_UNCONVERGED: c = '{blue: 8'd255, green: 8'd0,   red: 8'd255};
      CLS_CONSTRAINT:  c = '{blue: 8'd0,   green: 8'd64,  red: 8'd255};
      CLS_INIT_ERROR:  c = '{blue: 8'd0,   green: 8'd255, red: 8'd255};
      CLS_TRANSFER:    c = '{blue: 8'd0,   green: 8'd0,   red: 8'd255};
      CLS_UNKNOWN:     c = '{blue: 8'd0,   green: 8'd255, red: 8'd255};
      default:         c = '{blue: 8'd0,   green: 8'd255, red: 8'd255};
    endcase
    return c;
  endfunction

  // smallest mapped index whose srgb code reaches k (elaboration only)
  function automatic logic [16:0] gamma_thresh(input int tone_bits, input int k);
    logic [299:0] scale;
    logic [299:0] lhs;
    logic [299:0] rhs;
    longint       lin_cnt;
    longint       lo;
    longint       hi;
    longint       mid;
    longint       i;
    int           p;
    logic         found;
    logic [16:0]  res;
    res     = '0;
    found   = 1'b0;
    lin_cnt = 0;
    while ((lin_cnt * 64'sd10000000) <= (longint'(31308) << tone_bits)) begin
      lin_cnt++;
    end
    if (k == 0) begin
      found = 1'b1;
    end
    // linear segment near black
    for (i = 0; i < lin_cnt; i++) begin
      if (!found && ((64'sd65892 * i) >= (longint'(20 * k - 10) << tone_bits))) begin
        found = 1'b1;
        res   = 17'(i);
      end
    end
    // power segment, exact integer compare
    if (!found) begin
      scale = 300'd1;
      rhs   = 300'd1;
      for (p = 0; p < 12; p++) begin
        scale = scale * 300'd53805;
        rhs   = rhs * 300'(200 * k + 2705);
      end
      rhs = rhs << (5 * tone_bits);
      lo  = lin_cnt;
      hi  = (longint'(1) << tone_bits) + 1;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        lhs = scale;
        for (p = 0; p < 5; p++) begin
          lhs = lhs * 300'(mid);
        end
        if (lhs >= rhs) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
      res = 17'(lo);
    end
    return res;
  endfunction

endpackage

/* hw/rtl/rptm_div.sv */
// pipelined restoring divider, one quotient bit per stage, for the tone map ratio
module rptm_div import rptm_pkg::*; #(
  parameter int TONE_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  rptm_tag_t                  tag_in,
  input  logic                       inf_in,
  input  logic [DEN_W+TONE_BITS-1:0] num_in,
  input  logic [DEN_W-1:0]           den_in,
  output rptm_tag_t                  tag_out,
  output logic [TONE_BITS:0]         quo_out
);

  localparam int NS = TONE_BITS + 1;
  localparam int NW = DEN_W + TONE_BITS;

  rptm_tag_t          tag [NS];
  logic               inf [NS];
  logic [TONE_BITS:0] quo [NS];
  logic [NW-1:0]      rem [NS-1];
  logic [DEN_W-1:0]   den [NS-1];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    rptm_tag_t          t_in;
    logic               i_in;
    logic [NW-1:0]      r_in;
    logic [DEN_W-1:0]   d_in;
    logic [TONE_BITS:0] q_in;
    logic [TONE_BITS:0] q_next;
    logic [NW-1:0]      d_sh;
    logic               ge;

    if (s == 0) begin : g_first
      assign t_in = tag_in;
      assign i_in = inf_in;
      assign r_in = num_in;
      assign d_in = den_in;
      assign q_in = '0;
    end else begin : g_rest
      assign t_in = tag[s-1];
      assign i_in = inf[s-1];
      assign r_in = rem[s-1];
      assign d_in = den[s-1];
      assign q_in = quo[s-1];
    end

    assign d_sh = NW'(d_in) << (TONE_BITS - s);
    assign ge   = r_in >= d_sh;

    always_comb begin
      q_next                = q_in;
      q_next[TONE_BITS - s] = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        tag[s] <= '0;
      end else if (en) begin
        tag[s] <= t_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        inf[s] <= i_in;
        quo[s] <= q_next;
      end
    end

    if (s < NS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s] <= ge ? (r_in - d_sh) : r_in;
          den[s] <= d_in;
        end
      end
    end
  end

  assign tag_out = tag[NS-1];
  assign quo_out = inf[NS-1] ? ((TONE_BITS + 1)'(1) << TONE_BITS) : quo[NS-1];

endmodule

/* hw/rtl/rptm_gamma.sv */
// pipelined search of the srgb code thresholds, one code bit per stage
module rptm_gamma import rptm_pkg::*; #(
  parameter int TONE_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  rptm_tag_t          tag_in,
  input  logic [TONE_BITS:0] idx_in,
  output rptm_tag_t          tag_out,
  output logic [7:0]         grey_out
);

  localparam int NS = 8;
  localparam int TW = TONE_BITS + 2;

  logic [TW-1:0]      thr [256];
  rptm_tag_t          tag [NS];
  logic [7:0]         acc [NS];
  logic [TONE_BITS:0] idx [NS-1];

  for (genvar k = 0; k < 256; k++) begin : g_thr
    localparam logic [16:0] THR_K = gamma_thresh(TONE_BITS, k);
    assign thr[k] = TW'(THR_K);
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    rptm_tag_t          t_in;
    logic [TONE_BITS:0] x_in;
    logic [7:0]         a_in;
    logic [7:0]         cand;
    logic               take;

    if (s == 0) begin : g_first
      assign t_in = tag_in;
      assign x_in = idx_in;
      assign a_in = '0;
    end else begin : g_rest
      assign t_in = tag[s-1];
      assign x_in = idx[s-1];
      assign a_in = acc[s-1];
    end

    assign cand = a_in | (8'd1 << (NS - 1 - s));
    assign take = thr[cand] <= TW'(x_in);

    always_ff @(posedge clk) begin
      if (rst) begin
        tag[s] <= '0;
      end else if (en) begin
        tag[s] <= t_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc[s] <= take ? cand : a_in;
      end
    end

    if (s < NS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          idx[s] <= x_in;
        end
      end
    end
  end

  assign tag_out  = tag[NS-1];
  assign grey_out = acc[NS-1];

endmodule

/* hw/rtl/ray_pixel_tone_mapper_core.sv */
// ray pixel tone mapper: exposure, reinhard tone map, srgb gamma and class colors
// exposure multiply, saturate, ratio operands, divider, gamma search, output register
// throughput: one item per cycle; the whole pipeline holds while the output item waits
// the divider takes TONE_BITS + 1 stages, the gamma search 8 stages
// reset: synchronous, clears all valid bits and sets exposure to 1.0; no clearing pass
module ray_pixel_tone_mapper_core import rptm_pkg::*; #(
  parameter int TONE_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [EXPOSURE_W-1:0] cfg_wr_data,   // exposure
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,  // intensity
  input  logic [2:0]            s_axis_tuser,  // ray_class
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [47:0]           m_axis_tdata   // beauty_red, beauty_green, beauty_blue,
                                               // class_red, class_green, class_blue
);

  localparam int NW = DEN_W + TONE_BITS;
  localparam int PW = INTENSITY_W + EXPOSURE_W;

  logic [EXPOSURE_W-1:0] exposure;
  logic                  en;

  rptm_tag_t             tag0;
  logic                  inf0;
  logic [PW-1:0]         prod0;
  rptm_tag_t             tag1;
  logic                  inf1;
  logic [31:0]           lin1;
  rptm_tag_t             tag2;
  logic                  inf2;
  logic [NW-1:0]         num2;
  logic [DEN_W-1:0]      den2;
  rptm_tag_t             div_tag;
  logic [TONE_BITS:0]    div_quo;
  rptm_tag_t             gam_tag;
  logic [7:0]            gam_grey;
  logic                  out_valid;
  rptm_rgb_t             out_beauty;
  rptm_rgb_t             out_class;
  rptm_rgb_t             cls_rgb;
  logic [PW-FRAC_W-1:0]  lin_wide;

  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      exposure <= EXPOSURE_INIT;
    end else if (cfg_wr_en) begin
      exposure <= cfg_wr_data;
    end
  end

  // exposure multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      tag0 <= '0;
    end else if (en) begin
      tag0.valid     <= s_axis_tvalid;
      tag0.ray_class <= rptm_class_t'(s_axis_tuser);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inf0  <= (&s_axis_tdata) && (exposure != '0);
      prod0 <= PW'(s_axis_tdata) * PW'(exposure);
    end
  end

  // drop fraction and saturate
  assign lin_wide = prod0[PW-1:FRAC_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
    end else if (en) begin
      tag1 <= tag0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inf1 <= inf0;
      lin1 <= (|lin_wide[PW-FRAC_W-1:32]) ? '1 : lin_wide[31:0];
    end
  end

  // rounded ratio operands
  always_ff @(posedge clk) begin
    if (rst) begin
      tag2 <= '0;
    end else if (en) begin
      tag2 <= tag1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inf2 <= inf1;
      den2 <= DEN_W'(lin1) + DEN_W'(65536);
      num2 <= (NW'(lin1) << TONE_BITS) + NW'(lin1 >> 1) + NW'(32768);
    end
  end

  rptm_div #(
    .TONE_BITS (TONE_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .tag_in  (tag2),
    .inf_in  (inf2),
    .num_in  (num2),
    .den_in  (den2),
    .tag_out (div_tag),
    .quo_out (div_quo)
  );

  rptm_gamma #(
    .TONE_BITS (TONE_BITS)
  ) u_gamma (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .tag_in   (div_tag),
    .idx_in   (div_quo),
    .tag_out  (gam_tag),
    .grey_out (gam_grey)
  );

  // output register
  assign cls_rgb = class_color(gam_tag.ray_class);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= gam_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_class <= cls_rgb;
      if (gam_tag.ray_class inside {[CLS_UNCONVERGED:CLS_UNKNOWN]}) begin
        out_beauty <= cls_rgb;
      end else begin
        out_beauty <= '{blue: gam_grey, green: gam_grey, red: gam_grey};
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_class.blue, out_class.green, out_class.red,
                          out_beauty.blue, out_beauty.green, out_beauty.red};

endmodule
